// ===== design/audio_ring_latency_capped_upmix_core_macros.svh =====
// Assertion macros for the audio ring core
`ifndef AUDIO_RING_LATENCY_CAPPED_UPMIX_CORE_MACROS_SVH
`define AUDIO_RING_LATENCY_CAPPED_UPMIX_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ARUCU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("audio ring core check failed");
`define ARUCU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("audio ring core check failed");
`else
`define ARUCU_ASSERT_NOW(lbl, ante, cons)
`define ARUCU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/arucu_pkg.sv =====
package arucu_pkg;

    localparam int RING_DEPTH_DEF     = 65536;
    localparam int MAX_OUT_CH_DEF     = 8;
    localparam int QUEUE_DEPTH        = 4;
    localparam int OC_W               = 5;
    localparam int SRC_SLOTS          = 3;

    localparam logic [1:0]  CFG_SOURCE_CH = 2'd0;
    localparam logic [1:0]  CFG_OUT_CH    = 2'd1;
    localparam logic [1:0]  CFG_MAX_BUF   = 2'd2;
    localparam logic [1:0]  CFG_FLOAT_OUT = 2'd3;

    localparam logic [1:0]  SC_RESET = 2'd1;
    localparam logic [3:0]  OC_RESET = 4'd1;
    localparam logic [16:0] MB_RESET = 17'd11520;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    localparam logic [17:0] RECIP3 = 18'd174763;

    typedef struct packed {
        logic [1:0]  source_channels;
        logic [3:0]  out_channels;
        logic [16:0] max_buffered;
    } t_cfg;

    typedef struct packed {
        logic [SRC_SLOTS-1:0][15:0] smp;
        logic [1:0]                 sc;
        logic [OC_W-1:0]            oc;
        logic                       have;
    } t_pull_entry;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_CAP,
        FS_ALIGN,
        FS_COUNT,
        FS_READ,
        FS_LAND,
        FS_PUT
    } t_front_state;

    function automatic logic [1:0] mod3_32(input logic [31:0] v);
        logic [6:0] s;
        logic [4:0] t;
        s = 7'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + {3'b000, v[i*4 +: 4]};
        end
        t = {1'b0, s[3:0]} + {2'b00, s[6:4]};
        if (t >= 5'd12) t = t - 5'd12;
        if (t >= 5'd6)  t = t - 5'd6;
        if (t >= 5'd3)  t = t - 5'd3;
        return t[1:0];
    endfunction

    function automatic logic [16:0] div_by_sc(input logic [17:0] x, input logic [1:0] sc);
        logic [35:0] p;
        logic [16:0] q;
        p = {18'd0, x} * {18'd0, RECIP3};
        case (sc)
            2'd2:    q = x[17:1];
            2'd3:    q = p[35:19];
            default: q = x[16:0];
        endcase
        return q;
    endfunction

    function automatic logic [31:0] f32_of_s16(input logic [15:0] raw);
        logic [15:0] mag;
        logic [3:0]  p;
        logic [7:0]  e;
        logic [38:0] wide;
        mag  = raw[15] ? (16'd0 - raw) : raw;
        p    = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mag[i]) p = 4'(i);
        end
        e    = {4'b0000, p} + 8'd112;
        wide = {23'd0, mag} << (5'd23 - {1'b0, p});
        if (raw == 16'd0) return 32'd0;
        return {raw[15], e, wide[22:0]};
    endfunction

endpackage

// ===== design/arucu_ram.sv =====
module arucu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/arucu_front.sv =====
module arucu_front #(
    parameter int RING_DEPTH       = 65536,
    parameter int MAX_OUT_CHANNELS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  arucu_pkg::t_cfg               i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic signed [15:0]            i_sample_in,
    input  logic                          i_block_start,
    output logic                          o_ram_we,
    output logic [$clog2(RING_DEPTH)-1:0] o_ram_waddr,
    output logic [15:0]                   o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(RING_DEPTH)-1:0] o_ram_raddr,
    input  logic [15:0]                   i_ram_rdata,
    output logic                          o_q_push,
    output arucu_pkg::t_pull_entry        o_q_entry,
    input  logic                          i_q_full
);

    import arucu_pkg::*;

    localparam int RA_W = $clog2(RING_DEPTH);

    t_front_state r_state, n_state;

    logic        r_ib_valid;
    logic        r_ib_kind;
    logic [15:0] r_ib_sample;
    logic        r_ib_block;

    logic [31:0] r_wc, n_wc;
    logic [31:0] r_rc, n_rc;
    logic [16:0] r_frames, n_frames;
    logic [31:0] r_tmp, n_tmp;
    logic [1:0]  r_j, n_j;
    logic        r_have, n_have;
    logic        r_cap_en;
    logic [1:0]  r_cap_slot;
    logic [SRC_SLOTS-1:0][15:0] r_smp;

    logic            take;
    logic [1:0]      sc_eff;
    logic [OC_W-1:0] oc_eff;
    logic [31:0]     backlog;
    logic            over_cap;
    logic [1:0]      rem;
    logic [16:0]     frames_calc;

    always_comb begin
        sc_eff = (i_cfg.source_channels == 2'd0) ? 2'd1 : i_cfg.source_channels;
        if (i_cfg.out_channels == 4'd0) begin
            oc_eff = OC_W'(1);
        end else if ({1'b0, i_cfg.out_channels} > 5'(MAX_OUT_CHANNELS)) begin
            oc_eff = OC_W'(MAX_OUT_CHANNELS);
        end else begin
            oc_eff = OC_W'(i_cfg.out_channels);
        end
    end

    assign take     = (r_state == FS_IDLE) && r_ib_valid;
    assign o_in_ready = !r_ib_valid || take;

    assign backlog  = r_wc - r_rc;
    assign over_cap = backlog > {15'd0, i_cfg.max_buffered};

    always_comb begin
        case (sc_eff)
            2'd2:    rem = {1'b0, r_tmp[0]};
            2'd3:    rem = mod3_32(r_tmp);
            default: rem = 2'd0;
        endcase
    end

    assign frames_calc = div_by_sc(backlog[17:0], sc_eff);

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (take && (r_ib_kind == KIND_PULL)) begin
                    if (r_ib_block) begin
                        n_state = FS_CAP;
                    end else if (r_frames != 17'd0) begin
                        n_state = FS_READ;
                    end else begin
                        n_state = FS_PUT;
                    end
                end
            end
            FS_CAP:   n_state = over_cap ? FS_ALIGN : FS_COUNT;
            FS_ALIGN: n_state = FS_COUNT;
            FS_COUNT: n_state = (frames_calc != 17'd0) ? FS_READ : FS_PUT;
            FS_READ:  n_state = (r_j == sc_eff - 2'd1) ? FS_LAND : FS_READ;
            FS_LAND:  n_state = FS_PUT;
            FS_PUT:   n_state = i_q_full ? FS_PUT : FS_IDLE;
            default:  n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        n_wc     = r_wc;
        n_rc     = r_rc;
        n_frames = r_frames;
        n_tmp    = r_tmp;
        n_j      = r_j;
        n_have   = r_have;
        case (r_state)
            FS_IDLE: begin
                n_j = 2'd0;
                if (take && (r_ib_kind == KIND_PUSH)) begin
                    n_wc = r_wc + 32'd1;
                end
                n_have = r_frames != 17'd0;
            end
            FS_CAP:   n_tmp = r_wc - {15'd0, i_cfg.max_buffered};
            FS_ALIGN: n_rc = r_tmp - {30'd0, rem};
            FS_COUNT: begin
                n_frames = frames_calc;
                n_have   = frames_calc != 17'd0;
            end
            FS_READ:  n_j = r_j + 2'd1;
            FS_PUT: begin
                if (!i_q_full && r_have) begin
                    n_rc     = r_rc + {30'd0, sc_eff};
                    n_frames = r_frames - 17'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_ram_we    = take && (r_ib_kind == KIND_PUSH);
    assign o_ram_waddr = r_wc[RA_W-1:0];
    assign o_ram_wdata = r_ib_sample;
    assign o_ram_re    = r_state == FS_READ;
    assign o_ram_raddr = r_rc[RA_W-1:0] + RA_W'(r_j);

    assign o_q_push       = (r_state == FS_PUT) && !i_q_full;
    assign o_q_entry.smp  = r_smp;
    assign o_q_entry.sc   = sc_eff;
    assign o_q_entry.oc   = oc_eff;
    assign o_q_entry.have = r_have;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_IDLE;
            r_ib_valid <= 1'b0;
            r_wc       <= 32'd0;
            r_rc       <= 32'd0;
            r_frames   <= 17'd0;
            r_cap_en   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wc       <= n_wc;
            r_rc       <= n_rc;
            r_frames   <= n_frames;
            r_cap_en   <= r_state == FS_READ;
            if (o_in_ready) begin
                r_ib_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tmp      <= n_tmp;
        r_j        <= n_j;
        r_have     <= n_have;
        r_cap_slot <= r_j;
        if (o_in_ready && i_in_valid) begin
            r_ib_kind   <= i_kind;
            r_ib_sample <= i_sample_in;
            r_ib_block  <= i_block_start;
        end
        if (r_cap_en) begin
            r_smp[r_cap_slot] <= i_ram_rdata;
        end
    end

endmodule

// ===== design/arucu_queue.sv =====
module arucu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_rd, r_wr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
    endfunction

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != CNT_W'(0);
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

// ===== design/arucu_back.sv =====
module arucu_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  arucu_pkg::t_pull_entry i_entry,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic signed [15:0]     o_sample_s16,
    output logic [31:0]            o_sample_f32_bits,
    output logic [2:0]             o_channel_index,
    output logic                   o_last_in_frame
);

    import arucu_pkg::*;

    logic [OC_W-1:0] r_c;
    logic            r_s1_valid;
    logic [15:0]     r_s1_sample;
    logic [2:0]      r_s1_chan;
    logic            r_s1_last;
    logic            r_o_valid;
    logic [15:0]     r_o_s16;
    logic [31:0]     r_o_f32;
    logic [2:0]      r_o_chan;
    logic            r_o_last;

    logic        out_load;
    logic        s1_adv;
    logic        s1_open;
    logic        emit;
    logic [1:0]  sc_m1;
    logic [1:0]  src;
    logic        last;
    logic [15:0] sample;

    assign out_load = !r_o_valid || i_out_ready;
    assign s1_adv   = r_s1_valid && out_load;
    assign s1_open  = !r_s1_valid || s1_adv;
    assign emit     = s1_open && i_q_valid;

    assign sc_m1  = i_entry.sc - 2'd1;
    assign src    = (r_c > {{(OC_W-2){1'b0}}, sc_m1}) ? sc_m1 : r_c[1:0];
    assign last   = (r_c + OC_W'(1)) == i_entry.oc;
    assign sample = i_entry.have ? i_entry.smp[src] : 16'd0;

    assign o_q_pop = emit && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c        <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (emit) begin
                r_c <= last ? OC_W'(0) : r_c + OC_W'(1);
            end
            if (s1_open) begin
                r_s1_valid <= emit;
            end
            if (out_load) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_sample <= sample;
            r_s1_chan   <= r_c[2:0];
            r_s1_last   <= last;
        end
        if (s1_adv) begin
            r_o_s16  <= r_s1_sample;
            r_o_f32  <= f32_of_s16(r_s1_sample);
            r_o_chan <= r_s1_chan;
            r_o_last <= r_s1_last;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_sample_s16      = r_o_s16;
    assign o_sample_f32_bits = r_o_f32;
    assign o_channel_index   = r_o_chan;
    assign o_last_in_frame   = r_o_last;

endmodule

// ===== design/audio_ring_latency_capped_upmix_core.sv =====
// Push: one transfer per cycle while the front is idle; the buffered sample is written to the
// ring when the front takes it. Pull: a block start passes CAP, ALIGN (backlog capped) and
// COUNT; then READ for each of S (source channels read from the ring port), LAND, PUT, or
// straight to PUT on underrun. Back emits one channel sample per cycle unless the queue is
// empty or the output stalls, out_channels samples per frame. Reset (sync, active low) clears
// counts, frame count, queue and pipeline, loads register defaults; ring is not cleared.
`include "audio_ring_latency_capped_upmix_core_macros.svh"

module audio_ring_latency_capped_upmix_core #(
    parameter int RING_DEPTH       = arucu_pkg::RING_DEPTH_DEF,
    parameter int MAX_OUT_CHANNELS = arucu_pkg::MAX_OUT_CH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [16:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [15:0] i_sample_in,
    input  logic               i_block_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample_s16,
    output logic [31:0]        o_sample_f32_bits,
    output logic [2:0]         o_channel_index,
    output logic               o_last_in_frame
);

    import arucu_pkg::*;

    localparam int RA_W = $clog2(RING_DEPTH);

    t_cfg        r_cfg;
    logic        ram_we;
    logic [RA_W-1:0] ram_waddr;
    logic [15:0] ram_wdata;
    logic        ram_re;
    logic [RA_W-1:0] ram_raddr;
    logic [15:0] ram_rdata;
    logic        q_push;
    t_pull_entry q_in;
    logic        q_full;
    logic        q_valid;
    logic [$bits(t_pull_entry)-1:0] q_out;
    logic        q_pop;
    logic        out_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_channels <= SC_RESET;
            r_cfg.out_channels    <= OC_RESET;
            r_cfg.max_buffered    <= MB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SOURCE_CH: r_cfg.source_channels <= i_cfg_wdata[1:0];
                CFG_OUT_CH:    r_cfg.out_channels    <= i_cfg_wdata[3:0];
                CFG_MAX_BUF:   r_cfg.max_buffered    <= i_cfg_wdata;
                CFG_FLOAT_OUT: ;
                default: ;
            endcase
        end
    end

    arucu_front #(
        .RING_DEPTH       (RING_DEPTH),
        .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_sample_in   (i_sample_in),
        .i_block_start (i_block_start),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_q_push      (q_push),
        .o_q_entry     (q_in),
        .i_q_full      (q_full)
    );

    arucu_ram #(
        .WIDTH (16),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    arucu_queue #(
        .WIDTH ($bits(t_pull_entry)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    arucu_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_entry           (t_pull_entry'(q_out)),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_sample_s16      (o_sample_s16),
        .o_sample_f32_bits (o_sample_f32_bits),
        .o_channel_index   (o_channel_index),
        .o_last_in_frame   (o_last_in_frame)
    );

    assign out_xfer = o_out_valid && i_out_ready;

    `ARUCU_ASSERT_NEXT(a_frame_no_gap, out_xfer && !o_last_in_frame, o_out_valid)
    `ARUCU_ASSERT_NEXT(a_chan_steps, out_xfer && !o_last_in_frame, o_channel_index == $past(o_channel_index) + 3'd1)
    `ARUCU_ASSERT_NOW(a_zero_float, o_out_valid && (o_sample_s16 == 16'sd0), o_sample_f32_bits == 32'd0)

endmodule
